### design/oplcsd_pkg.sv
package oplcsd_pkg;

   // Input opcodes
   localparam logic [1:0] OP_STREAM  = 2'd0;
   localparam logic [1:0] OP_TABLE   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // Stream formats
   localparam logic [1:0] FMT_IMF0 = 2'd0;
   localparam logic [1:0] FMT_IMF1 = 2'd1;
   localparam logic [1:0] FMT_DRO1 = 2'd2;
   localparam logic [1:0] FMT_DRO2 = 2'd3;

   // DRO1 command codes
   localparam logic [7:0] DRO1_SHORT   = 8'd0;
   localparam logic [7:0] DRO1_LONG    = 8'd1;
   localparam logic [7:0] DRO1_BANK_LO = 8'd2;
   localparam logic [7:0] DRO1_BANK_HI = 8'd3;
   localparam logic [7:0] DRO1_ESC     = 8'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_FORMAT      = 2'd0;
   localparam logic [1:0] CSR_SHORT_DELAY = 2'd1;
   localparam logic [1:0] CSR_LONG_DELAY  = 2'd2;
   localparam logic [1:0] CSR_MUTE_MASK   = 2'd3;

   localparam int CSR_DATA_W  = 9;
   localparam int TABLE_DEPTH = 128;
   localparam int TABLE_AW    = 7;

   localparam logic [7:0] LONG_DELAY_RESET = 8'd1;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_IMF   = 3'd1,
      KIND_SHORT = 3'd2,
      KIND_LONG1 = 3'd3,
      KIND_LONG2 = 3'd4,
      KIND_DATA  = 3'd5,
      KIND_ESC   = 3'd6
   } kind_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] byte_value;
      logic [6:0] table_index;
   } req_type;

   typedef struct packed {
      logic        write_enable;
      logic        bank;
      logic [7:0]  reg_addr;
      logic [7:0]  write_data;
      logic [16:0] delay_ticks;
   } rsp_type;

endpackage

### design/opl_command_stream_decoder_core.sv
// OPL command stream decoder. Feed the bytes of an IMF, DRO1 or DRO2 register
// stream one beat at a time on the req_ channel (opcode 0); each completed
// command produces one rsp_ beat holding a chip register write and/or a delay
// in ticks (0..65536). Opcode 1 loads one entry of the 128-entry DRO2 register
// code table, opcode 2 restarts the parser (table and registers are kept).
// Throughput is one beat per cycle: every byte is decoded by a single pass of
// logic into one result register, and a new beat is taken whenever that
// register is empty or being drained in the same cycle, so req_stall only
// follows rsp_stall while a result is held. rsp_valid is registered and rises
// in the cycle after the final byte is accepted. The code table is a RAM with
// registered read; it is read when a DRO2 command byte arrives and its data
// is used with the following data byte. A table entry never loaded since
// reset reads as zero. Writes to registers of muted low-bank melodic channels
// come out with write_enable cleared. Change csr_ registers only while the
// block is idle; csr_ready is always high.
module opl_command_stream_decoder_core (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  oplcsd_pkg::req_type  req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output oplcsd_pkg::rsp_type  rsp_data,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [8:0]           csr_data
);
   import oplcsd_pkg::*;

   // Mute lookup: map a register number to its melodic channel and test
   // the mask. High-bank registers never match these ranges.
   function automatic logic reg_muted(input logic [8:0] r, input logic [8:0] mask);
      logic       hit;
      logic [3:0] ch;
      hit = 1'b0;
      ch  = 4'd0;
      if ((r >= 9'h0A0 && r <= 9'h0A8) || (r >= 9'h0B0 && r <= 9'h0B8) ||
          (r >= 9'h0C0 && r <= 9'h0C8)) begin
         hit = 1'b1;
         ch  = r[3:0];
      end else if ((r >= 9'h020 && r <= 9'h035) || (r >= 9'h040 && r <= 9'h055) ||
                   (r >= 9'h060 && r <= 9'h075) || (r >= 9'h080 && r <= 9'h095) ||
                   (r >= 9'h0E0 && r <= 9'h0F5)) begin
         hit = 1'b1;
         case (r[4:0]) inside
            5'd0, 5'd3:   ch = 4'd0;
            5'd1, 5'd4:   ch = 4'd1;
            5'd2, 5'd5:   ch = 4'd2;
            5'd8, 5'd11:  ch = 4'd3;
            5'd9, 5'd12:  ch = 4'd4;
            5'd10, 5'd13: ch = 4'd5;
            5'd16, 5'd19: ch = 4'd6;
            5'd17, 5'd20: ch = 4'd7;
            5'd18, 5'd21: ch = 4'd8;
            default:      hit = 1'b0;
         endcase
      end
      return hit && mask[ch];
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [1:0] format_ff;
   logic [7:0] short_code_ff;
   logic [7:0] long_code_ff;
   logic [8:0] mute_mask_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff     <= FMT_IMF0;
         short_code_ff <= 8'd0;
         long_code_ff  <= LONG_DELAY_RESET;
         mute_mask_ff  <= 9'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FORMAT:      format_ff     <= csr_data[1:0];
            CSR_SHORT_DELAY: short_code_ff <= csr_data[7:0];
            CSR_LONG_DELAY:  long_code_ff  <= csr_data[7:0];
            CSR_MUTE_MASK:   mute_mask_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    accept;

   // Hold the input only while a result sits unconsumed.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Code table: RAM plus one valid bit per entry (unwritten reads zero)
   // ---------------------------------------------------------------------
   logic [TABLE_DEPTH-1:0] tbl_valid_ff;
   logic                   tbl_wr;
   logic                   tbl_rd;
   logic [7:0]             tbl_q;

   oplcsd_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_DEPTH)
   ) u_code_table (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (req_data.table_index),
      .wr_data (req_data.byte_value),
      .rd_en   (tbl_rd),
      .rd_addr (req_data.byte_value[TABLE_AW-1:0]),
      .rd_data (tbl_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
      end else if (tbl_wr) begin
         tbl_valid_ff[req_data.table_index] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------------
   logic [1:0] phase_ff, phase_in;
   kind_type   kind_ff, kind_in;
   logic [8:0] held_reg_ff, held_reg_in;
   logic [7:0] held_data_ff, held_data_in;
   logic [7:0] held_low_ff, held_low_in;
   logic       hi_bank_ff, hi_bank_in;
   logic       tbl_sel_ff, tbl_sel_in;   // held_reg[7:0] comes from the table
   logic       tbl_hit_ff, tbl_hit_in;   // table entry was loaded at read time

   logic [7:0] b;
   logic [8:0] data_reg;
   logic       emit;
   logic [8:0] emit_reg;
   logic [7:0] emit_dat;
   logic [16:0] emit_dly;
   logic        emit_wr;

   assign b = req_data.byte_value;

   // Register named by a pending data command, resolved through the table.
   assign data_reg = tbl_sel_ff ? {held_reg_ff[8], (tbl_hit_ff ? tbl_q : 8'd0)}
                                : held_reg_ff;

   always_comb begin
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      held_reg_in  = held_reg_ff;
      held_data_in = held_data_ff;
      held_low_in  = held_low_ff;
      hi_bank_in   = hi_bank_ff;
      tbl_sel_in   = tbl_sel_ff;
      tbl_hit_in   = tbl_hit_ff;
      tbl_wr       = 1'b0;
      tbl_rd       = 1'b0;
      emit         = 1'b0;
      emit_wr      = 1'b0;
      emit_reg     = 9'd0;
      emit_dat     = 8'd0;
      emit_dly     = 17'd0;

      if (accept) begin
         unique case (req_data.opcode)
            OP_TABLE: begin
               tbl_wr = 1'b1;
            end
            OP_RESTART: begin
               phase_in     = 2'd0;
               kind_in      = KIND_NONE;
               held_reg_in  = 9'd0;
               held_data_in = 8'd0;
               held_low_in  = 8'd0;
               hi_bank_in   = 1'b0;
               tbl_sel_in   = 1'b0;
            end
            OP_STREAM: begin
               unique case (kind_ff)
                  KIND_IMF: begin
                     if (phase_ff <= 2'd1) begin
                        held_data_in = b;
                        phase_in     = 2'd2;
                     end else if (phase_ff == 2'd2) begin
                        held_low_in = b;
                        phase_in    = 2'd3;
                     end else begin
                        emit     = 1'b1;
                        emit_wr  = 1'b1;
                        emit_reg = {1'b0, held_reg_ff[7:0]};
                        emit_dat = held_data_ff;
                        emit_dly = {1'b0, b, held_low_ff};
                     end
                  end
                  KIND_SHORT: begin
                     emit     = 1'b1;
                     emit_dly = 17'({1'b0, b} + 9'd1);
                  end
                  KIND_LONG1: begin
                     if (phase_ff == 2'd0) begin
                        held_low_in = b;
                        phase_in    = 2'd1;
                     end else begin
                        emit     = 1'b1;
                        emit_dly = {1'b0, b, held_low_ff} + 17'd1;
                     end
                  end
                  KIND_LONG2: begin
                     emit     = 1'b1;
                     emit_dly = {({1'b0, b} + 9'd1), 8'h00};
                  end
                  KIND_DATA: begin
                     emit     = 1'b1;
                     emit_wr  = 1'b1;
                     emit_reg = data_reg;
                     emit_dat = b;
                  end
                  KIND_ESC: begin
                     held_reg_in = {hi_bank_ff, b};
                     tbl_sel_in  = 1'b0;
                     kind_in     = KIND_DATA;
                  end
                  default: begin
                     // No command pending: this byte opens one.
                     phase_in = 2'd0;
                     if (format_ff == FMT_IMF0 || format_ff == FMT_IMF1) begin
                        held_reg_in = {1'b0, b};
                        tbl_sel_in  = 1'b0;
                        kind_in     = KIND_IMF;
                        phase_in    = 2'd1;
                     end else if (format_ff == FMT_DRO1) begin
                        unique case (b)
                           DRO1_SHORT:   kind_in = KIND_SHORT;
                           DRO1_LONG:    kind_in = KIND_LONG1;
                           DRO1_BANK_LO: begin
                              hi_bank_in = 1'b0;
                              kind_in    = KIND_NONE;
                           end
                           DRO1_BANK_HI: begin
                              hi_bank_in = 1'b1;
                              kind_in    = KIND_NONE;
                           end
                           DRO1_ESC:     kind_in = KIND_ESC;
                           default: begin
                              held_reg_in = {hi_bank_ff, b};
                              tbl_sel_in  = 1'b0;
                              kind_in     = KIND_DATA;
                           end
                        endcase
                     end else if (b == short_code_ff) begin
                        kind_in = KIND_SHORT;
                     end else if (b == long_code_ff) begin
                        kind_in = KIND_LONG2;
                     end else begin
                        // Look up the register now; the data byte uses it.
                        tbl_rd      = 1'b1;
                        tbl_hit_in  = tbl_valid_ff[b[TABLE_AW-1:0]];
                        tbl_sel_in  = 1'b1;
                        held_reg_in = {b[7], 8'd0};
                        kind_in     = KIND_DATA;
                     end
                  end
               endcase

               // A finished command drops all parser state but the bank.
               if (emit) begin
                  phase_in     = 2'd0;
                  kind_in      = KIND_NONE;
                  held_reg_in  = 9'd0;
                  held_data_in = 8'd0;
                  held_low_in  = 8'd0;
                  tbl_sel_in   = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 2'd0;
         kind_ff      <= KIND_NONE;
         held_reg_ff  <= 9'd0;
         held_data_ff <= 8'd0;
         held_low_ff  <= 8'd0;
         hi_bank_ff   <= 1'b0;
         tbl_sel_ff   <= 1'b0;
         tbl_hit_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         held_reg_ff  <= held_reg_in;
         held_data_ff <= held_data_in;
         held_low_ff  <= held_low_in;
         hi_bank_ff   <= hi_bank_in;
         tbl_sel_ff   <= tbl_sel_in;
         tbl_hit_ff   <= tbl_hit_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_data_in              = rsp_data_ff;
      rsp_valid_in             = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.write_enable = emit_wr && !reg_muted(emit_reg, mute_mask_ff);
         rsp_data_in.bank         = emit_reg[8];
         rsp_data_in.reg_addr     = emit_reg[7:0];
         rsp_data_in.write_data   = emit_dat;
         rsp_data_in.delay_ticks  = emit_dly;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/oplcsd_ram.sv
module oplcsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
